// ===== hdl/lodc_pkg.sv =====
// Shared constants, types and helpers of the lock-order deadlock checker.
`default_nettype none
package lodc_pkg;
    localparam int MAX_LOCKS   = 32;
    localparam int STACK_DEPTH = 16;
    localparam int KEY_BITS    = 32;
    localparam int ID_W        = $clog2(MAX_LOCKS);
    localparam int CNT_W       = $clog2(MAX_LOCKS + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int DEP_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DOUBLE   = 3'd1,
        ST_WRONG    = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_FULL     = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOK   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_EROW   = 8'b0000_1000,
        S_SRCH   = 8'b0001_0000,
        S_SWAIT  = 8'b0010_0000,
        S_PUSH   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    // index of the lowest set bit
    function automatic logic [ID_W-1:0] lowest_set(input logic [MAX_LOCKS-1:0] m);
        logic [ID_W-1:0] r;
        r = '0;
        for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
            if (m[i]) r = ID_W'(i);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/lodc_if.sv =====
// Handshake channels for requests and results.
`default_nettype none
interface lodc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] lock_key;
    modport source (output valid, output operation, output lock_key, input ready);
    modport sink   (input valid, input operation, input lock_key, output ready);
endinterface

interface lodc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] lock_id;
    logic [4:0] held_count;
    modport source (output valid, output status, output lock_id, output held_count,
                    input ready);
    modport sink   (input valid, input status, input lock_id, input held_count,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/lodc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lodc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/lock_order_deadlock_checker.sv =====
// Top level of the lock-order deadlock checker.
`default_nettype none
// Tracks acquire/release transfers against a lock-order graph held in RAM. Keys get
// dense ids on first acquire; each acquire that adds a new ordering edge runs a
// reachability search from the new lock back to the lock on top of the held
// stack, and a hit is reported as a deadlock. Errors are sticky until reset.
// One item at a time: a key lookup scans the key RAM one entry per cycle, and
// a search reads one edge row per reachable lock, issuing the read in S_SRCH
// and checking the row in S_SWAIT. The result register lets the next request
// enter while a result waits to be taken.
module lock_order_deadlock_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lodc_in_if.sink    i_in,
    lodc_out_if.source o_out
);
    localparam int N  = lodc_pkg::MAX_LOCKS;
    localparam int IW = lodc_pkg::ID_W;
    localparam int CW = lodc_pkg::CNT_W;
    localparam int SW = lodc_pkg::SP_W;
    localparam int DW = lodc_pkg::DEP_W;
    localparam int KW = lodc_pkg::KEY_BITS;

    lodc_pkg::t_state  r_state, n_state;
    logic              r_op, n_op;
    logic [KW-1:0]     r_key, n_key;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_id, n_id;
    logic              r_found, n_found;
    logic [IW-1:0]     r_prev, n_prev;
    logic [CW-1:0]     r_known, n_known;
    logic [DW-1:0]     r_depth, n_depth;
    lodc_pkg::t_status r_fault, n_fault;
    lodc_pkg::t_status r_status, n_status;
    logic [N-1:0]      r_reach, n_reach;
    logic [N-1:0]      r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_o_status, n_o_status;
    logic [4:0]        r_o_id, n_o_id;
    logic [4:0]        r_o_held, n_o_held;

    logic          key_we, key_re;
    logic [IW-1:0] key_waddr, key_raddr;
    logic [KW-1:0] key_rdata;
    logic          edge_we, edge_re;
    logic [IW-1:0] edge_waddr, edge_raddr;
    logic [N-1:0]  edge_wdata, edge_rdata;
    logic          held_we, held_re;
    logic [SW-1:0] held_waddr, held_raddr;
    logic [IW-1:0] held_rdata;

    logic          accept;
    logic [IW-1:0] id_c;
    logic [IW-1:0] v_c;

    lodc_ram #(.WIDTH(KW), .DEPTH(N)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(r_key),
        .i_re(key_re), .i_raddr(key_raddr), .o_rdata(key_rdata)
    );
    lodc_ram #(.WIDTH(N), .DEPTH(N)) u_edges (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_re(edge_re), .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );
    lodc_ram #(.WIDTH(IW), .DEPTH(lodc_pkg::STACK_DEPTH)) u_held (
        .i_clk(i_clk), .i_we(held_we), .i_waddr(held_waddr), .i_wdata(r_id),
        .i_re(held_re), .i_raddr(held_raddr), .o_rdata(held_rdata)
    );

    assign i_in.ready       = (r_state == lodc_pkg::S_IDLE);
    assign accept           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_o_status;
    assign o_out.lock_id    = r_o_id;
    assign o_out.held_count = r_o_held;

    assign id_c = r_found ? r_id : r_known[IW-1:0];
    assign v_c  = lodc_pkg::lowest_set(r_pend);

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_key = r_key;
        n_idx = r_idx;       n_id = r_id;       n_found = r_found;
        n_prev = r_prev;     n_known = r_known; n_depth = r_depth;
        n_fault = r_fault;   n_status = r_status;
        n_reach = r_reach;   n_pend = r_pend;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_status = r_o_status; n_o_id = r_o_id; n_o_held = r_o_held;
        key_we = 1'b0;  key_waddr = r_known[IW-1:0];
        key_re = 1'b0;  key_raddr = '0;
        edge_we = 1'b0; edge_waddr = r_prev; edge_wdata = '0;
        edge_re = 1'b0; edge_raddr = '0;
        held_we = 1'b0; held_waddr = r_depth[SW-1:0];
        held_re = 1'b0; held_raddr = SW'(r_depth - DW'(1));

        case (r_state)
            lodc_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = i_in.operation;
                    n_key    = i_in.lock_key[KW-1:0];
                    n_id     = '0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = lodc_pkg::ST_OK;
                    key_re   = 1'b1;
                    held_re  = 1'b1;
                    if (r_fault != lodc_pkg::ST_OK) begin
                        n_status = r_fault;
                        n_state  = lodc_pkg::S_RESP;
                    end else if (i_in.operation == lodc_pkg::OP_RELEASE && r_depth == '0)
                    begin
                        n_status = lodc_pkg::ST_DOUBLE;
                        n_state  = lodc_pkg::S_RESP;
                    end else if (r_known == '0) begin
                        n_state = lodc_pkg::S_DECIDE;
                    end else begin
                        n_state = lodc_pkg::S_LOOK;
                    end
                end
            end
            lodc_pkg::S_LOOK: begin
                // key_rdata holds entry r_idx
                if (key_rdata == r_key) begin
                    n_found = 1'b1;
                    n_id    = r_idx;
                    n_state = lodc_pkg::S_DECIDE;
                end else if (CW'(r_idx) + CW'(1) >= r_known) begin
                    n_state = lodc_pkg::S_DECIDE;
                end else begin
                    n_idx     = r_idx + IW'(1);
                    key_re    = 1'b1;
                    key_raddr = r_idx + IW'(1);
                end
            end
            lodc_pkg::S_DECIDE: begin
                if (r_op == lodc_pkg::OP_RELEASE) begin
                    n_state = lodc_pkg::S_RESP;
                    if (!r_found) begin
                        n_id     = '0;
                        n_status = lodc_pkg::ST_WRONG;
                    end else if (held_rdata != r_id) begin
                        n_status = lodc_pkg::ST_WRONG;
                    end else begin
                        n_depth = r_depth - DW'(1);
                    end
                end else if (!r_found && r_known == CW'(N)) begin
                    n_id     = '0;
                    n_status = lodc_pkg::ST_FULL;
                    n_state  = lodc_pkg::S_RESP;
                end else begin
                    if (!r_found) begin
                        key_we  = 1'b1;
                        n_known = r_known + CW'(1);
                        // clear the edge row of a newly assigned id
                        edge_we    = 1'b1;
                        edge_waddr = id_c;
                        edge_wdata = '0;
                    end
                    n_id   = id_c;
                    n_prev = held_rdata;
                    if (r_depth != '0 && held_rdata != id_c) begin
                        edge_re    = 1'b1;
                        edge_raddr = held_rdata;
                        n_state    = lodc_pkg::S_EROW;
                    end else begin
                        n_state = lodc_pkg::S_PUSH;
                    end
                end
            end
            lodc_pkg::S_EROW: begin
                if (edge_rdata[r_id]) begin
                    n_state = lodc_pkg::S_PUSH;
                end else begin
                    // record the edge, then search for a path back to prev
                    edge_we    = 1'b1;
                    edge_wdata = edge_rdata | (N'(1) << r_id);
                    n_reach    = N'(1) << r_id;
                    n_pend     = N'(1) << r_id;
                    n_state    = lodc_pkg::S_SRCH;
                end
            end
            lodc_pkg::S_SRCH: begin
                if (r_pend == '0) begin
                    n_state = lodc_pkg::S_PUSH;
                end else begin
                    n_pend     = r_pend & ~(N'(1) << v_c);
                    edge_re    = 1'b1;
                    edge_raddr = v_c;
                    n_state    = lodc_pkg::S_SWAIT;
                end
            end
            lodc_pkg::S_SWAIT: begin
                if (edge_rdata[r_prev]) begin
                    n_status = lodc_pkg::ST_DEADLOCK;
                    n_state  = lodc_pkg::S_RESP;
                end else begin
                    n_pend  = r_pend | (edge_rdata & ~r_reach);
                    n_reach = r_reach | edge_rdata;
                    n_state = lodc_pkg::S_SRCH;
                end
            end
            lodc_pkg::S_PUSH: begin
                if (r_depth >= DW'(lodc_pkg::STACK_DEPTH)) begin
                    n_status = lodc_pkg::ST_OVERFLOW;
                end else begin
                    held_we = 1'b1;
                    n_depth = r_depth + DW'(1);
                end
                n_state = lodc_pkg::S_RESP;
            end
            lodc_pkg::S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_id      = 5'(r_id);
                    n_o_held    = 5'(r_depth);
                    n_fault     = r_status;
                    n_state     = lodc_pkg::S_IDLE;
                end
            end
            default: n_state = lodc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lodc_pkg::S_IDLE;
            r_known     <= '0;
            r_depth     <= '0;
            r_fault     <= lodc_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_known     <= n_known;
            r_depth     <= n_depth;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
        r_op <= n_op;       r_key <= n_key;     r_idx <= n_idx;
        r_id <= n_id;       r_found <= n_found; r_prev <= n_prev;
        r_status <= n_status;
        r_reach <= n_reach; r_pend <= n_pend;
        r_o_status <= n_o_status; r_o_id <= n_o_id; r_o_held <= n_o_held;
    end

`ifndef ASSERT_OFF
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != lodc_pkg::ST_OK) |=> (r_fault == $past(r_fault)))
        else $error("fault code changed after being set");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(lodc_pkg::STACK_DEPTH))
        else $error("held depth beyond stack size");
    a_known_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known <= CW'(N))
        else $error("known count beyond table size");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lodc_pkg::S_RESP && (!r_out_valid || o_out.ready)) |=>
        (r_out_valid && r_state == lodc_pkg::S_IDLE))
        else $error("result not presented after completion");
`endif
endmodule
`default_nettype wire

// ===== tb/lock_order_deadlock_checker_tb.sv =====
// Testbench of the lock-order deadlock checker: queued stimulus, predictor and result scoreboard.
`default_nettype none
module lock_order_deadlock_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 1_500_000;

    typedef struct {
        lodc_pkg::t_op op;
        logic [31:0]   key;
        int            send_idle;
        int            recv_stall;
        bit            drain;
    } t_req;

    typedef struct {
        logic [2:0] status;
        logic [4:0] lock_id;
        logic [4:0] held_count;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lodc_in_if  req_ch ();
    lodc_out_if res_ch ();

    lock_order_deadlock_checker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   recv_stall_pct = 0;

    // predictor state
    logic [31:0] known_keys[lodc_pkg::MAX_LOCKS];
    int          known_num = 0;
    logic [31:0] order_rows[lodc_pkg::MAX_LOCKS];
    logic [4:0]  held_ids[lodc_pkg::STACK_DEPTH];
    int          held_num = 0;
    logic [2:0]  sticky_fault = lodc_pkg::ST_OK;

    initial begin
        for (int i = 0; i < lodc_pkg::MAX_LOCKS; i++) order_rows[i] = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = lodc_pkg::OP_ACQUIRE;
        req_ch.lock_key  = '0;
        res_ch.ready     = 1'b0;
    end

    function automatic bit find_key(input logic [31:0] key, output logic [4:0] id);
        id = '0;
        for (int i = 0; i < known_num; i++) begin
            if (known_keys[i] == key) begin
                id = 5'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit reaches(input logic [4:0] src, input logic [4:0] dst);
        logic [31:0] seen;
        seen = 32'd1 << src;
        for (int pass = 0; pass < lodc_pkg::MAX_LOCKS; pass++) begin
            for (int v = 0; v < lodc_pkg::MAX_LOCKS; v++) begin
                if (seen[v]) seen = seen | order_rows[v];
            end
        end
        return seen[dst];
    endfunction

    task automatic predict_lock_step(input lodc_pkg::t_op op, input logic [31:0] key);
        t_res       r;
        logic [2:0] st;
        logic [4:0] id;
        logic [4:0] prev;
        st = lodc_pkg::ST_OK;
        id = '0;
        if (sticky_fault != lodc_pkg::ST_OK) begin
            st = sticky_fault;
        end else if (op == lodc_pkg::OP_ACQUIRE) begin
            if (!find_key(key, id)) begin
                if (known_num >= lodc_pkg::MAX_LOCKS) begin
                    st = lodc_pkg::ST_FULL;
                end else begin
                    id = 5'(known_num);
                    known_keys[known_num] = key;
                    known_num++;
                end
            end
            if (st == lodc_pkg::ST_OK && held_num > 0) begin
                prev = held_ids[held_num-1];
                if (prev != id && !order_rows[prev][id]) begin
                    order_rows[prev][id] = 1'b1;
                    if (reaches(id, prev)) st = lodc_pkg::ST_DEADLOCK;
                end
            end
            if (st == lodc_pkg::ST_OK) begin
                if (held_num >= lodc_pkg::STACK_DEPTH) st = lodc_pkg::ST_OVERFLOW;
                else begin
                    held_ids[held_num] = id;
                    held_num++;
                end
            end
            if (st == lodc_pkg::ST_FULL) id = '0;
            sticky_fault = st;
        end else begin
            if (held_num == 0) begin
                st = lodc_pkg::ST_DOUBLE;
            end else if (!find_key(key, id)) begin
                id = '0;
                st = lodc_pkg::ST_WRONG;
            end else if (held_ids[held_num-1] != id) begin
                st = lodc_pkg::ST_WRONG;
            end else begin
                held_num--;
            end
            sticky_fault = st;
        end
        r.status     = st;
        r.lock_id    = id;
        r.held_count = 5'(held_num);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // driver
    always @(posedge i_clk) begin
        bit   take;
        bit   next_valid;
        t_req nxt;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            take = req_ch.valid && req_ch.ready;
            if (take) predict_lock_step(lodc_pkg::t_op'(req_ch.operation), req_ch.lock_key);
            next_valid = req_ch.valid && !take;
            if (!next_valid && pending_reqs.size() > 0) begin
                nxt = pending_reqs[0];
                if (!(nxt.drain && expected_results.size() > 0) &&
                    $urandom_range(99) >= nxt.send_idle) begin
                    void'(pending_reqs.pop_front());
                    next_valid = 1'b1;
                    recv_stall_pct = nxt.recv_stall;
                    req_ch.operation <= nxt.op;
                    req_ch.lock_key  <= nxt.key;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", res_ch.status, -1);
                end else begin
                    w = expected_results.pop_front();
                    if (res_ch.status !== w.status)
                        report_mismatch("status", res_ch.status, w.status);
                    if (res_ch.lock_id !== w.lock_id)
                        report_mismatch("lock_id", res_ch.lock_id, w.lock_id);
                    if (res_ch.held_count !== w.held_count)
                        report_mismatch("held_count", res_ch.held_count, w.held_count);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("lock_order_deadlock_checker_tb failed");
            $finish;
        end
    end

    // stimulus shadow: pool keys ranked by index, locks taken in rank order except in the closing fault case
    logic [31:0] key_pool[lodc_pkg::MAX_LOCKS];
    int          gen_stack[$];
    int          item_num = 0;

    task automatic add_req(input lodc_pkg::t_op op, input logic [31:0] key);
        t_req q;
        int   ph;
        ph = (item_num * 4) / 1900;
        q.op         = op;
        q.key        = key;
        q.send_idle  = (ph == 1) ? 77 : (ph == 3) ? 22 : 0;
        q.recv_stall = (ph == 2) ? 77 : (ph == 3) ? 22 : 0;
        q.drain      = (item_num == 1000) || (item_num == 1500);
        pending_reqs.push_back(q);
        item_num++;
    endtask

    task automatic gen_acquire(input int j);
        gen_stack.push_back(j);
        add_req(lodc_pkg::OP_ACQUIRE, key_pool[j]);
    endtask

    task automatic gen_release_top();
        add_req(lodc_pkg::OP_RELEASE, key_pool[gen_stack.pop_back()]);
    endtask

    task automatic gen_release_all();
        while (gen_stack.size() > 0) gen_release_top();
    endtask

    function automatic bit in_pool(input logic [31:0] k, input int upto);
        for (int i = 0; i < upto; i++) if (key_pool[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    initial begin
        int          top;
        int          ending;
        logic [31:0] k;
        key_pool[0]  = 32'h0000_0000;
        key_pool[31] = 32'hFFFF_FFFF;
        for (int i = 1; i < 31; i++) begin
            do k = $urandom(); while (in_pool(k, i) || k == 32'hFFFF_FFFF);
            key_pool[i] = k;
        end

        // directed: key extremes, re-acquire of the top lock, nested release
        gen_acquire(0);
        gen_acquire(31);
        gen_acquire(31);
        gen_release_top();
        gen_release_top();
        gen_acquire(0);
        gen_acquire(1);
        gen_acquire(30);
        gen_release_all();
        for (int d = 0; d < 15; d++) gen_acquire(d);
        gen_acquire(31);
        gen_release_all();

        // random well-formed nesting
        while (item_num < 1850) begin
            top = (gen_stack.size() > 0) ? gen_stack[$] : 0;
            if (gen_stack.size() < lodc_pkg::STACK_DEPTH &&
                (gen_stack.size() == 0 || $urandom_range(99) < 55))
                gen_acquire($urandom_range(31, top));
            else
                gen_release_top();
        end

        // one terminal fault, then sticky noise
        ending = $urandom_range(4);
        gen_release_all();
        case (ending)
            0: begin
                gen_acquire(2);
                gen_release_top();
                add_req(lodc_pkg::OP_RELEASE, key_pool[2]);
            end
            1: begin
                gen_acquire(3);
                gen_acquire(5);
                if ($urandom_range(1)) add_req(lodc_pkg::OP_RELEASE, key_pool[3]);
                else begin
                    do k = $urandom(); while (in_pool(k, lodc_pkg::MAX_LOCKS));
                    add_req(lodc_pkg::OP_RELEASE, k);
                end
            end
            2: begin
                gen_acquire(4);
                gen_acquire(9);
                gen_release_all();
                gen_acquire(9);
                gen_acquire(4);
            end
            3: begin
                for (int i = 0; i < lodc_pkg::MAX_LOCKS; i++) begin
                    gen_acquire(i);
                    gen_release_top();
                end
                do k = $urandom(); while (in_pool(k, lodc_pkg::MAX_LOCKS));
                add_req(lodc_pkg::OP_ACQUIRE, k);
            end
            default: begin
                for (int i = 0; i <= lodc_pkg::STACK_DEPTH; i++) gen_acquire(7);
            end
        endcase
        for (int i = 0; i < 60; i++) add_req(lodc_pkg::t_op'($urandom_range(1)), $urandom());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_ch.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("lock_order_deadlock_checker_tb passed");
        end else begin
            $display("lock_order_deadlock_checker_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
